/* rtl/i2cbs_pkg.sv */
// Shared types and constants for the I2C master bit sequencer.
package i2cbs_pkg;

	localparam int unsigned BitsPerByte = 8;
	localparam int unsigned PhaseW      = 5;

	localparam logic [PhaseW-1:0] LenStart   = PhaseW'(4);
	localparam logic [PhaseW-1:0] LenStop    = PhaseW'(3);
	localparam logic [PhaseW-1:0] LenWrite   = PhaseW'(3 * BitsPerByte);
	localparam logic [PhaseW-1:0] LenRead    = PhaseW'(1 + 3 * BitsPerByte);
	localparam logic [PhaseW-1:0] LenSendAck = PhaseW'(3);
	localparam logic [PhaseW-1:0] LenRecvAck = PhaseW'(4);

	typedef enum logic [2:0] {
		CMD_NONE    = 3'd0,
		CMD_START   = 3'd1,
		CMD_STOP    = 3'd2,
		CMD_WRITE   = 3'd3,
		CMD_READ    = 3'd4,
		CMD_SENDACK = 3'd5,
		CMD_RECVACK = 3'd6
	} cmd_t;

	typedef struct packed {
		cmd_t                   cmd;
		logic [BitsPerByte-1:0] data;
		logic                   ack;
		logic                   sda;
	} tick_t;

endpackage

/* rtl/i2cbs_front.sv */
// Front end: takes tick transactions, decodes the opcode and queues them.
module i2cbs_front #(
	parameter int unsigned QUEUE_DEPTH = 2
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             in_valid,
	output logic                             in_stall,
	input  logic [2:0]                       opcode,
	input  logic [i2cbs_pkg::BitsPerByte-1:0] data_byte,
	input  logic                             ack_level,
	input  logic                             sda_in,
	output logic                             q_valid,
	output i2cbs_pkg::tick_t                 q_head,
	input  logic                             q_pop
);

	localparam int unsigned PtrW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
	localparam int unsigned CntW = $clog2(QUEUE_DEPTH + 1);
	localparam logic [PtrW-1:0] LastPtr = PtrW'(QUEUE_DEPTH - 1);
	localparam logic [CntW-1:0] FullCnt = CntW'(QUEUE_DEPTH);

	i2cbs_pkg::tick_t mem_q [QUEUE_DEPTH];
	logic [PtrW-1:0]  wr_ptr_q;
	logic [PtrW-1:0]  rd_ptr_q;
	logic [CntW-1:0]  count_q;
	i2cbs_pkg::tick_t decoded;
	logic             push;
	logic             pop;

	always_comb begin
		case (opcode)
			i2cbs_pkg::CMD_START:   decoded.cmd = i2cbs_pkg::CMD_START;
			i2cbs_pkg::CMD_STOP:    decoded.cmd = i2cbs_pkg::CMD_STOP;
			i2cbs_pkg::CMD_WRITE:   decoded.cmd = i2cbs_pkg::CMD_WRITE;
			i2cbs_pkg::CMD_READ:    decoded.cmd = i2cbs_pkg::CMD_READ;
			i2cbs_pkg::CMD_SENDACK: decoded.cmd = i2cbs_pkg::CMD_SENDACK;
			i2cbs_pkg::CMD_RECVACK: decoded.cmd = i2cbs_pkg::CMD_RECVACK;
			default:                decoded.cmd = i2cbs_pkg::CMD_NONE;
		endcase
		decoded.data = data_byte;
		decoded.ack  = ack_level;
		decoded.sda  = sda_in;
	end

	assign in_stall = (count_q == FullCnt);
	assign q_valid  = (count_q != '0);
	assign q_head   = mem_q[rd_ptr_q];
	assign push     = in_valid && !in_stall;
	assign pop      = q_pop && q_valid;

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= decoded;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == LastPtr) ? '0 : wr_ptr_q + PtrW'(1);
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == LastPtr) ? '0 : rd_ptr_q + PtrW'(1);
			end
			case ({push, pop})
				2'b10:   count_q <= count_q + CntW'(1);
				2'b01:   count_q <= count_q - CntW'(1);
				default: count_q <= count_q;
			endcase
		end
	end

endmodule

/* rtl/i2cbs_back.sv */
// Back end: runs one bus tick per queued transaction and registers the result.
module i2cbs_back (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             q_valid,
	input  i2cbs_pkg::tick_t                 q_head,
	output logic                             q_pop,
	output logic                             out_valid,
	input  logic                             out_stall,
	output logic                             scl_level,
	output logic                             sda_level,
	output logic                             busy_res,
	output logic                             done_res,
	output logic [i2cbs_pkg::BitsPerByte-1:0] read_byte,
	output logic                             ack_seen
);

	localparam int unsigned BW = i2cbs_pkg::BitsPerByte;
	localparam int unsigned PW = i2cbs_pkg::PhaseW;

	i2cbs_pkg::cmd_t active_q;
	logic [PW-1:0]   phase_q;
	logic [1:0]      sub_q;
	logic [BW-1:0]   shift_q;
	logic            scl_q;
	logic            sda_q;
	logic            ack_q;
	logic            out_valid_q;

	i2cbs_pkg::cmd_t cmd;
	logic [PW-1:0]   phase;
	logic [1:0]      sub;
	logic [BW-1:0]   shift_n;
	logic            scl_n;
	logic            sda_n;
	logic            ack_n;
	logic [1:0]      sub_n;
	logic [PW-1:0]   len;
	logic            done;

	assign q_pop = q_valid && (!out_valid_q || !out_stall);

	always_comb begin
		cmd     = active_q;
		phase   = phase_q;
		sub     = sub_q;
		shift_n = shift_q;
		scl_n   = scl_q;
		sda_n   = sda_q;
		ack_n   = ack_q;
		if (active_q == i2cbs_pkg::CMD_NONE && q_head.cmd != i2cbs_pkg::CMD_NONE) begin
			cmd   = q_head.cmd;
			phase = '0;
			sub   = '0;
			if (q_head.cmd == i2cbs_pkg::CMD_WRITE) begin
				shift_n = q_head.data;
			end
			if (q_head.cmd == i2cbs_pkg::CMD_SENDACK) begin
				sda_n = q_head.ack;
			end
		end
		sub_n = (sub == 2'd2) ? 2'd0 : sub + 2'd1;
		len   = '0;
		case (cmd)
			i2cbs_pkg::CMD_START: begin
				len = i2cbs_pkg::LenStart;
				case (phase[1:0])
					2'd0:    sda_n = 1'b1;
					2'd1:    scl_n = 1'b1;
					2'd2:    sda_n = 1'b0;
					default: scl_n = 1'b0;
				endcase
			end
			i2cbs_pkg::CMD_STOP: begin
				len = i2cbs_pkg::LenStop;
				case (phase[1:0])
					2'd0:    sda_n = 1'b0;
					2'd1:    scl_n = 1'b1;
					default: sda_n = 1'b1;
				endcase
			end
			i2cbs_pkg::CMD_WRITE: begin
				len = i2cbs_pkg::LenWrite;
				case (sub)
					2'd0:    sda_n = shift_n[BW-1];
					2'd1:    scl_n = 1'b1;
					default: begin
						scl_n   = 1'b0;
						shift_n = {shift_n[BW-2:0], 1'b0};
					end
				endcase
			end
			i2cbs_pkg::CMD_READ: begin
				len = i2cbs_pkg::LenRead;
				if (phase == '0) begin
					sda_n   = 1'b1;
					shift_n = '0;
					sub_n   = '0;
				end else begin
					case (sub)
						2'd0:    scl_n = 1'b1;
						2'd1:    shift_n = {shift_n[BW-2:0], q_head.sda};
						default: scl_n = 1'b0;
					endcase
				end
			end
			i2cbs_pkg::CMD_SENDACK: begin
				len = i2cbs_pkg::LenSendAck;
				case (phase[1:0])
					2'd1:    scl_n = 1'b1;
					2'd2:    scl_n = 1'b0;
					default: scl_n = scl_n;
				endcase
			end
			i2cbs_pkg::CMD_RECVACK: begin
				len = i2cbs_pkg::LenRecvAck;
				case (phase[1:0])
					2'd0:    sda_n = 1'b1;
					2'd1:    scl_n = 1'b1;
					2'd2:    ack_n = q_head.sda;
					default: scl_n = 1'b0;
				endcase
			end
			default: len = '0;
		endcase
		done = (cmd != i2cbs_pkg::CMD_NONE) && (phase + PW'(1) == len);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			active_q    <= i2cbs_pkg::CMD_NONE;
			phase_q     <= '0;
			sub_q       <= '0;
			shift_q     <= '0;
			scl_q       <= 1'b1;
			sda_q       <= 1'b1;
			ack_q       <= 1'b0;
			out_valid_q <= 1'b0;
			scl_level   <= 1'b1;
			sda_level   <= 1'b1;
			busy_res    <= 1'b0;
			done_res    <= 1'b0;
			read_byte   <= '0;
			ack_seen    <= 1'b0;
		end else begin
			if (q_pop) begin
				active_q    <= done ? i2cbs_pkg::CMD_NONE : cmd;
				phase_q     <= done ? '0 : phase + PW'(1);
				sub_q       <= done ? '0 : sub_n;
				shift_q     <= shift_n;
				scl_q       <= scl_n;
				sda_q       <= sda_n;
				ack_q       <= ack_n;
				out_valid_q <= 1'b1;
				scl_level   <= scl_n;
				sda_level   <= sda_n;
				busy_res    <= (cmd != i2cbs_pkg::CMD_NONE) && !done;
				done_res    <= done;
				read_byte   <= (done && cmd == i2cbs_pkg::CMD_READ) ? shift_n : '0;
				ack_seen    <= done && cmd == i2cbs_pkg::CMD_RECVACK && ack_n;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign out_valid = out_valid_q;

endmodule

/* rtl/i2c_master_bit_sequencer_unit.sv */
// Top level of the I2C master bit sequencer: front queue and tick executor.
//
//  channel | valid     | stall     | payload
//  --------+-----------+-----------+---------------------------------------------
//  in      | in_valid  | in_stall  | opcode, data_byte, ack_level, sda_in
//  out     | out_valid | out_stall | scl_level, sda_level, busy_res, done_res,
//          |           |           | read_byte, ack_seen
//
// One tick transaction in, one result out; one tick per cycle sustained while out_stall is low.
// Each input passes through the queue and then the output register before its result appears.
// The queue of QUEUE_DEPTH entries absorbs output stalls; in_stall rises when it is full.
// Reset releases SCL and SDA (both 1) and leaves the sequencer idle.
module i2c_master_bit_sequencer_unit #(
	parameter int unsigned QUEUE_DEPTH = 2
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             in_valid,
	output logic                             in_stall,
	input  logic [2:0]                       opcode,
	input  logic [i2cbs_pkg::BitsPerByte-1:0] data_byte,
	input  logic                             ack_level,
	input  logic                             sda_in,
	output logic                             out_valid,
	input  logic                             out_stall,
	output logic                             scl_level,
	output logic                             sda_level,
	output logic                             busy_res,
	output logic                             done_res,
	output logic [i2cbs_pkg::BitsPerByte-1:0] read_byte,
	output logic                             ack_seen
);

	logic             q_valid;
	logic             q_pop;
	i2cbs_pkg::tick_t q_head;

	i2cbs_front #(
		.QUEUE_DEPTH(QUEUE_DEPTH)
	) u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.opcode    (opcode),
		.data_byte (data_byte),
		.ack_level (ack_level),
		.sda_in    (sda_in),
		.q_valid   (q_valid),
		.q_head    (q_head),
		.q_pop     (q_pop)
	);

	i2cbs_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.q_valid   (q_valid),
		.q_head    (q_head),
		.q_pop     (q_pop),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.scl_level (scl_level),
		.sda_level (sda_level),
		.busy_res  (busy_res),
		.done_res  (done_res),
		.read_byte (read_byte),
		.ack_seen  (ack_seen)
	);

endmodule
